/* hdl/sspq_pkg.sv */
// Package for the stable sorted priority queue.
// Holds command and status codes and the control struct shared by top and cells.
// No dependencies.
`default_nettype none
package sspq_pkg;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_POP_EMPTY  = 2'd1;
    localparam logic [1:0] ST_PUSH_FULL  = 2'd2;
    localparam logic [1:0] ST_RESERVED   = 2'd3;

    typedef struct packed {
        logic push;
        logic pop;
    } t_cell_ctl;

endpackage
`default_nettype wire

/* hdl/stable_sorted_priority_queue_top.sv */
// Top level of the stable sorted priority queue: a chain of sspq_cell entries
// plus entry count and output register. Depends on sspq_pkg and sspq_cell.
//
// Channel   Dir  tdata (low bit up)                  tuser
// s_axis    in   key, payload, zero fill             command
// m_axis    out  out_key, out_payload, entry_count,  pop_valid, status
//                zero fill
//
// One item per cycle while the output is not stalled: every cell compares its key
// against the pushed key in parallel and shifts one place, so a push or pop completes
// in the accept cycle. The result appears in the output register in the cycle after.
// Reset clears the entry count and the output valid; cell contents stay as is.
// A stalled result holds the output register and blocks input until taken.
`default_nettype none
module stable_sorted_priority_queue_top #(
    parameter int CAPACITY    = 256,
    parameter int KEY_BITS    = 32,
    parameter int HANDLE_BITS = 9
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_s_tvalid,
    output logic                    o_s_tready,
    input  wire  [((KEY_BITS+HANDLE_BITS+7)/8)*8-1:0] i_s_tdata, // key, payload
    input  wire                     i_s_tuser,                   // command
    output logic                    o_m_tvalid,
    input  wire                     i_m_tready,
    output logic [((KEY_BITS+HANDLE_BITS+$clog2(CAPACITY+1)+7)/8)*8-1:0] o_m_tdata,
                                    // out_key, out_payload, entry_count
    output logic [2:0]              o_m_tuser                    // pop_valid, status
);

    localparam int CW     = $clog2(CAPACITY + 1);
    localparam int OUT_DW = KEY_BITS + HANDLE_BITS + CW;
    localparam int OUT_W  = ((OUT_DW + 7) / 8) * 8;

    logic [CW-1:0]          r_count;
    logic [CW-1:0]          n_count;
    logic                   r_m_valid;
    logic                   r_pop_valid;
    logic [KEY_BITS-1:0]    r_out_key;
    logic [HANDLE_BITS-1:0] r_out_handle;
    logic [1:0]             r_status;
    logic [CW-1:0]          r_out_count;

    logic                   w_accept;
    logic                   w_empty;
    logic                   w_full;
    logic [KEY_BITS-1:0]    w_key;
    logic [HANDLE_BITS-1:0] w_handle;
    sspq_pkg::t_cell_ctl    w_ctl;

    logic [CAPACITY-1:0]    w_ins;
    logic [KEY_BITS-1:0]    w_cell_key    [CAPACITY];
    logic [HANDLE_BITS-1:0] w_cell_handle [CAPACITY];

    assign o_s_tready = !r_m_valid || i_m_tready;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_empty    = (r_count == '0);
    assign w_full     = (r_count == CW'(CAPACITY));
    assign w_key      = i_s_tdata[KEY_BITS-1:0];
    assign w_handle   = i_s_tdata[KEY_BITS+HANDLE_BITS-1:KEY_BITS];

    assign w_ctl.push = w_accept && (i_s_tuser == sspq_pkg::CMD_PUSH) && !w_full;
    assign w_ctl.pop  = w_accept && (i_s_tuser == sspq_pkg::CMD_POP) && !w_empty;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic                   w_left_ins;
            logic [KEY_BITS-1:0]    w_left_key;
            logic [HANDLE_BITS-1:0] w_left_handle;
            logic [KEY_BITS-1:0]    w_right_key;
            logic [HANDLE_BITS-1:0] w_right_handle;

            if (g == 0) begin : g_head
                assign w_left_ins    = 1'b0;
                assign w_left_key    = w_key;
                assign w_left_handle = w_handle;
            end else begin : g_body
                assign w_left_ins    = w_ins[g-1];
                assign w_left_key    = w_cell_key[g-1];
                assign w_left_handle = w_cell_handle[g-1];
            end

            if (g == CAPACITY - 1) begin : g_tail
                assign w_right_key    = w_cell_key[g];
                assign w_right_handle = w_cell_handle[g];
            end else begin : g_mid
                assign w_right_key    = w_cell_key[g+1];
                assign w_right_handle = w_cell_handle[g+1];
            end

            sspq_cell #(
                .KEY_BITS    (KEY_BITS),
                .HANDLE_BITS (HANDLE_BITS)
            ) u_cell (
                .i_clk          (i_clk),
                .i_ctl          (w_ctl),
                .i_occupied     (r_count > CW'(g)),
                .i_new_key      (w_key),
                .i_new_handle   (w_handle),
                .i_left_ins     (w_left_ins),
                .i_left_key     (w_left_key),
                .i_left_handle  (w_left_handle),
                .i_right_key    (w_right_key),
                .i_right_handle (w_right_handle),
                .o_ins          (w_ins[g]),
                .o_key          (w_cell_key[g]),
                .o_handle       (w_cell_handle[g])
            );
        end
    endgenerate

    always_comb begin
        n_count = r_count;
        if (w_ctl.push) begin
            n_count = r_count + CW'(1);
        end else if (w_ctl.pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_count  <= n_count;
            r_pop_valid  <= w_ctl.pop;
            r_out_key    <= w_ctl.pop ? w_cell_key[0] : '0;
            r_out_handle <= w_ctl.pop ? w_cell_handle[0] : '0;
            if (i_s_tuser == sspq_pkg::CMD_POP) begin
                r_status <= w_empty ? sspq_pkg::ST_POP_EMPTY : sspq_pkg::ST_OK;
            end else begin
                r_status <= w_full ? sspq_pkg::ST_PUSH_FULL : sspq_pkg::ST_OK;
            end
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tuser  = {r_status, r_pop_valid};
    assign o_m_tdata  = OUT_W'({r_out_count, r_out_handle, r_out_key});

endmodule
`default_nettype wire

/* hdl/sspq_cell.sv */
// One storage cell of the sorted chain: holds one (key, handle) entry.
// Depends on sspq_pkg for the control struct.
`default_nettype none
module sspq_cell #(
    parameter int KEY_BITS    = 32,
    parameter int HANDLE_BITS = 9
) (
    input  wire                      i_clk,
    input  wire sspq_pkg::t_cell_ctl i_ctl,
    input  wire                      i_occupied,
    input  wire  [KEY_BITS-1:0]      i_new_key,
    input  wire  [HANDLE_BITS-1:0]   i_new_handle,
    input  wire                      i_left_ins,
    input  wire  [KEY_BITS-1:0]      i_left_key,
    input  wire  [HANDLE_BITS-1:0]   i_left_handle,
    input  wire  [KEY_BITS-1:0]      i_right_key,
    input  wire  [HANDLE_BITS-1:0]   i_right_handle,
    output logic                     o_ins,
    output logic [KEY_BITS-1:0]      o_key,
    output logic [HANDLE_BITS-1:0]   o_handle
);

    logic [KEY_BITS-1:0]    r_key;
    logic [HANDLE_BITS-1:0] r_handle;
    logic [KEY_BITS-1:0]    n_key;
    logic [HANDLE_BITS-1:0] n_handle;

    // The new entry lands at or before this slot
    assign o_ins    = !i_occupied || (r_key > i_new_key);
    assign o_key    = r_key;
    assign o_handle = r_handle;

    always_comb begin
        n_key    = r_key;
        n_handle = r_handle;
        if (i_ctl.pop) begin
            n_key    = i_right_key;
            n_handle = i_right_handle;
        end else if (i_ctl.push && o_ins) begin
            if (i_left_ins) begin
                n_key    = i_left_key;
                n_handle = i_left_handle;
            end else begin
                n_key    = i_new_key;
                n_handle = i_new_handle;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key    <= n_key;
        r_handle <= n_handle;
    end

endmodule
`default_nettype wire

/* hdl/sspq_checker.sv */
// Port-level checker for stable_sorted_priority_queue_top, with its bind.
// Depends on sspq_pkg for status codes.
`default_nettype none
module sspq_checker #(
    parameter int CAPACITY    = 256,
    parameter int KEY_BITS    = 32,
    parameter int HANDLE_BITS = 9
) (
    input wire                     i_clk,
    input wire                     i_rst_n,
    input wire                     o_m_tvalid,
    input wire                     i_m_tready,
    input wire [((KEY_BITS+HANDLE_BITS+$clog2(CAPACITY+1)+7)/8)*8-1:0] o_m_tdata,
    input wire [2:0]               o_m_tuser
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0] w_count;
    logic [1:0]    w_status;

    assign w_count  = o_m_tdata[KEY_BITS+HANDLE_BITS+CW-1:KEY_BITS+HANDLE_BITS];
    assign w_status = o_m_tuser[2:1];

    a_valid_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser)))
        else $error("stalled result changed");

    a_pop_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> (w_status == sspq_pkg::ST_OK))
        else $error("popped entry with error status");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (w_status != sspq_pkg::ST_RESERVED && w_count <= CW'(CAPACITY)))
        else $error("bad status or count beyond capacity");

    a_count_limits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && w_status == sspq_pkg::ST_PUSH_FULL) |-> (w_count == CW'(CAPACITY)))
        else $error("full push reported without full count");

endmodule

bind stable_sorted_priority_queue_top sspq_checker #(
    .CAPACITY    (CAPACITY),
    .KEY_BITS    (KEY_BITS),
    .HANDLE_BITS (HANDLE_BITS)
) u_sspq_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
`default_nettype wire
